/* rtl/heading_pid_controller_top_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef HEADING_PID_CONTROLLER_TOP_MACROS_SVH
`define HEADING_PID_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define HPC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define HPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPC_ASSERT(lbl, prop)
`define HPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/hpc_pkg.sv */
`timescale 1ns / 1ps

package hpc_pkg;

    localparam int HEAD_W  = 9;
    localparam int TIME_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 7;
    localparam int DRIVE_W = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 7;
    localparam int PTERM_W = 24;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH,
        S_RUN,
        S_SUM,
        S_DONE
    } st_t;

    typedef enum logic [2:0] {
        OP_INC,
        OP_IMUL,
        OP_IDIV,
        OP_DMUL,
        OP_DSCALE,
        OP_DDIV,
        OP_PMUL
    } op_t;

    typedef enum logic {
        MODE_MUL,
        MODE_DIV
    } su_mode_t;

    typedef struct packed {
        logic               start;
        su_mode_t           mode;
        logic [CNT_W-1:0]   steps;
    } su_cmd_t;

    localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd4;

    localparam logic [HEAD_W-1:0]  RST_TARGET = 9'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P = 16'd6144;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I = 16'd6144;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D = 16'd614;
    localparam logic [LIMIT_W-1:0] RST_LIMIT  = 7'd60;

    localparam logic [TIME_W-1:0] TWO_US_PER_S = 32'd2000000;
    localparam logic [TIME_W-1:0] US_PER_S     = 32'd1000000;

    localparam logic signed [10:0] HALF_TURN = 11'sd180;
    localparam logic signed [10:0] FULL_TURN = 11'sd360;
    localparam logic signed [HEAD_W-1:0] DEADBAND = 9'sd5;

    // serial step counts: bits of the narrow multiplier operand
    localparam logic [CNT_W-1:0] STEPS_ESUM  = 7'd9;
    localparam logic [CNT_W-1:0] STEPS_GAIN  = 7'd16;
    localparam logic [CNT_W-1:0] STEPS_SCALE = 7'd20;
    localparam logic [CNT_W-1:0] STEPS_ERR   = 7'd8;

endpackage

/* rtl/hpc_serial_unit.sv */
`timescale 1ns / 1ps
`include "heading_pid_controller_top_macros.svh"

// Shared bit-serial unit: shift-add multiply, restoring divide, one bit per cycle.
module hpc_serial_unit #(
    parameter int WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hpc_pkg::su_cmd_t    cmd,
    input  logic [WIDTH-1:0]    op_a,
    input  logic [WIDTH-1:0]    op_b,
    output logic [WIDTH-1:0]    result,
    output logic                done
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    hpc_pkg::su_mode_t          mode_reg, mode_next;
    logic [hpc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WIDTH-1:0]           acc_reg, acc_next;
    logic [WIDTH-1:0]           sh_reg, sh_next;
    logic [WIDTH-1:0]           op_reg, op_next;
    logic [WIDTH:0]             trial;
    logic [WIDTH:0]             trial_sub;
    logic                       fits;

    assign trial     = {acc_reg, sh_reg[WIDTH-1]};
    assign trial_sub = trial - {1'b0, op_reg};
    assign fits      = trial >= {1'b0, op_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        op_next   = op_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            mode_next = cmd.mode;
            acc_next  = '0;
            if (cmd.mode == hpc_pkg::MODE_DIV)
            begin
                cnt_next = hpc_pkg::CNT_W'(WIDTH);
                sh_next  = op_a;
                op_next  = op_b;
            end
            else
            begin
                cnt_next = cmd.steps;
                sh_next  = op_b;
                op_next  = op_a;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == hpc_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            unique case (mode_reg)
                hpc_pkg::MODE_MUL:
                begin
                    if (sh_reg[0])
                    begin
                        acc_next = acc_reg + op_reg;
                    end
                    op_next = {op_reg[WIDTH-2:0], 1'b0};
                    sh_next = {1'b0, sh_reg[WIDTH-1:1]};
                end
                hpc_pkg::MODE_DIV:
                begin
                    if (fits)
                    begin
                        acc_next = trial_sub[WIDTH-1:0];
                        sh_next  = {sh_reg[WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = trial[WIDTH-1:0];
                        sh_next  = {sh_reg[WIDTH-2:0], 1'b0};
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= hpc_pkg::MODE_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        op_reg  <= op_next;
    end

    assign result = (mode_reg == hpc_pkg::MODE_MUL) ? acc_reg : sh_reg;
    assign done   = done_reg;

    `HPC_ASSERT(a_start_idle, cmd.start |-> !busy_reg)
    `HPC_ASSERT(a_done_idle, done_reg |-> !busy_reg)
    `HPC_ASSERT_NEXT(a_last_step, busy_reg && (cnt_reg == hpc_pkg::CNT_W'(1)), done_reg)

endmodule

/* rtl/heading_pid_controller_top.sv */
`timescale 1ns / 1ps
`include "heading_pid_controller_top_macros.svh"

// The shared bit-serial multiply/divide unit sets the time per item, mainly the two
//   full-width restoring divides (integral scale, derivative over dt).
// Input is stalled from transfer until the result is loaded into the output register.
// Reset: async, active low; integral, previous error and time clear, registers to defaults.
module heading_pid_controller_top #(
    parameter int INTEGRAL_WIDTH     = 48,
    parameter int GAIN_FRACTION_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [hpc_pkg::HEAD_W-1:0]  heading,
    input  logic [hpc_pkg::TIME_W-1:0]  timestamp_us,
    input  logic                        restart,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [hpc_pkg::DRIVE_W-1:0] drive,
    output logic                        clamped,
    // configuration writes
    input  logic                        cfg_we,
    input  logic [hpc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [hpc_pkg::CFG_W-1:0]   cfg_data
);

    localparam int IW = INTEGRAL_WIDTH;
    // unit width: gain times integral magnitude is the widest operand
    localparam int NW = INTEGRAL_WIDTH + hpc_pkg::GAIN_W;
    localparam int SW = NW + 2;

    localparam logic signed [SW-1:0] I_MAX = {{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}};
    localparam logic signed [SW-1:0] I_MIN = {{(SW-IW+1){1'b1}}, {(IW-1){1'b0}}};

    // configuration
    logic [hpc_pkg::HEAD_W-1:0]  target_reg;
    logic [hpc_pkg::GAIN_W-1:0]  gain_p_reg;
    logic [hpc_pkg::GAIN_W-1:0]  gain_i_reg;
    logic [hpc_pkg::GAIN_W-1:0]  gain_d_reg;
    logic [hpc_pkg::LIMIT_W-1:0] limit_reg;

    // control and loop state
    hpc_pkg::st_t state_reg, state_next;
    hpc_pkg::op_t op_reg, op_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [IW-1:0]           integ_reg, integ_next;
    logic signed [hpc_pkg::HEAD_W-1:0] perr_reg, perr_next;
    logic [hpc_pkg::TIME_W-1:0]     ptime_reg, ptime_next;

    // payload
    logic signed [hpc_pkg::HEAD_W-1:0] e_reg, e_next;
    logic [hpc_pkg::TIME_W-1:0]     dt_reg, dt_next;
    logic [NW-1:0]                  tmp_reg, tmp_next;
    logic [NW-1:0]                  iterm_reg, iterm_next;
    logic [NW-1:0]                  dterm_reg, dterm_next;
    logic [hpc_pkg::PTERM_W-1:0]    pterm_reg, pterm_next;
    logic signed [SW-1:0]           sum_reg, sum_next;
    logic signed [hpc_pkg::DRIVE_W-1:0] drive_reg, drive_next;
    logic                           clamped_reg, clamped_next;

    // serial unit
    hpc_pkg::su_cmd_t   cmd;
    logic [NW-1:0]      op_a;
    logic [NW-1:0]      op_b;
    logic [NW-1:0]      unit_res;
    logic               unit_done;

    logic               in_fire;
    logic               out_free;

    // error wrap and dt at transfer
    logic signed [10:0] diff;
    logic signed [10:0] wrap1;
    logic signed [10:0] wrap2;
    logic [hpc_pkg::TIME_W-1:0] dt_in;

    logic signed [9:0]  esum;
    logic signed [9:0]  ediff;
    logic [9:0]         esum_abs;
    logic [9:0]         ediff_abs;
    logic [hpc_pkg::HEAD_W-1:0] e_abs;
    logic [IW-1:0]      integ_abs;

    logic signed [SW-1:0] integ_ext;
    logic signed [SW-1:0] inc_mag;
    logic signed [SW-1:0] inc_s;
    logic signed [SW-1:0] sat_sum;

    logic signed [SW-1:0] p_s;
    logic signed [SW-1:0] i_s;
    logic signed [SW-1:0] d_s;

    logic [SW-1:0]      sum_abs;
    logic [SW-1:0]      sum_shift;
    logic               over;
    logic [hpc_pkg::DRIVE_W-1:0] mag8;
    logic               in_band;

    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign diff  = $signed({2'b00, heading}) - $signed({2'b00, target_reg});
    assign wrap1 = (diff <= -hpc_pkg::HALF_TURN) ? diff + hpc_pkg::FULL_TURN : diff;
    assign wrap2 = (wrap1 >= hpc_pkg::HALF_TURN) ? wrap1 - hpc_pkg::FULL_TURN : wrap1;
    // restart: previous time counts as zero
    assign dt_in = timestamp_us - (restart ? '0 : ptime_reg);

    assign esum      = {e_reg[hpc_pkg::HEAD_W-1], e_reg} + {perr_reg[hpc_pkg::HEAD_W-1], perr_reg};
    assign ediff     = {e_reg[hpc_pkg::HEAD_W-1], e_reg} - {perr_reg[hpc_pkg::HEAD_W-1], perr_reg};
    assign esum_abs  = esum[9] ? 10'(-esum) : 10'(esum);
    assign ediff_abs = ediff[9] ? 10'(-ediff) : 10'(ediff);
    assign e_abs     = e_reg[hpc_pkg::HEAD_W-1] ? hpc_pkg::HEAD_W'(-e_reg)
                                                : hpc_pkg::HEAD_W'(e_reg);
    assign integ_abs = integ_reg[IW-1] ? IW'(-integ_reg) : IW'(integ_reg);

    // saturating integral update
    assign integ_ext = {{(SW-IW){integ_reg[IW-1]}}, integ_reg};
    assign inc_mag   = $signed({2'b00, unit_res});
    assign inc_s     = esum[9] ? -inc_mag : inc_mag;
    assign sat_sum   = integ_ext + inc_s;

    // signed terms
    assign p_s = e_reg[hpc_pkg::HEAD_W-1]
               ? -$signed({{(SW-hpc_pkg::PTERM_W){1'b0}}, pterm_reg})
               :  $signed({{(SW-hpc_pkg::PTERM_W){1'b0}}, pterm_reg});
    assign i_s = integ_reg[IW-1] ? -$signed({2'b00, iterm_reg}) : $signed({2'b00, iterm_reg});
    assign d_s = ediff[9] ? -$signed({2'b00, dterm_reg}) : $signed({2'b00, dterm_reg});

    // drive = trunc(-sum / 2^F), clamped
    assign sum_abs   = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign sum_shift = sum_abs >> GAIN_FRACTION_BITS;
    assign over      = sum_shift > SW'(limit_reg);
    assign mag8      = over ? {1'b0, limit_reg} : sum_shift[hpc_pkg::DRIVE_W-1:0];
    assign in_band   = (e_reg >= -hpc_pkg::DEADBAND) && (e_reg <= hpc_pkg::DEADBAND);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hpc_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = hpc_pkg::S_LAUNCH;
                end
            end
            hpc_pkg::S_LAUNCH:
            begin
                state_next = hpc_pkg::S_RUN;
            end
            hpc_pkg::S_RUN:
            begin
                if (unit_done)
                begin
                    state_next = (op_reg == hpc_pkg::OP_PMUL) ? hpc_pkg::S_SUM
                                                              : hpc_pkg::S_LAUNCH;
                end
            end
            hpc_pkg::S_SUM:
            begin
                state_next = hpc_pkg::S_DONE;
            end
            hpc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = hpc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hpc_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: stall and unit command
    always_comb
    begin
        in_stall   = (state_reg != hpc_pkg::S_IDLE);
        cmd.start  = (state_reg == hpc_pkg::S_LAUNCH);
        cmd.mode   = hpc_pkg::MODE_MUL;
        cmd.steps  = hpc_pkg::STEPS_GAIN;
        op_a       = '0;
        op_b       = '0;
        unique case (op_reg)
            hpc_pkg::OP_INC:
            begin
                cmd.steps = hpc_pkg::STEPS_ESUM;
                op_a      = NW'(dt_reg);
                op_b      = NW'(esum_abs);
            end
            hpc_pkg::OP_IMUL:
            begin
                cmd.steps = hpc_pkg::STEPS_GAIN;
                op_a      = NW'(integ_abs);
                op_b      = NW'(gain_i_reg);
            end
            hpc_pkg::OP_IDIV:
            begin
                cmd.mode  = hpc_pkg::MODE_DIV;
                op_a      = tmp_reg;
                op_b      = NW'(hpc_pkg::TWO_US_PER_S);
            end
            hpc_pkg::OP_DMUL:
            begin
                cmd.steps = hpc_pkg::STEPS_ESUM;
                op_a      = NW'(gain_d_reg);
                op_b      = NW'(ediff_abs);
            end
            hpc_pkg::OP_DSCALE:
            begin
                cmd.steps = hpc_pkg::STEPS_SCALE;
                op_a      = tmp_reg;
                op_b      = NW'(hpc_pkg::US_PER_S);
            end
            hpc_pkg::OP_DDIV:
            begin
                cmd.mode  = hpc_pkg::MODE_DIV;
                op_a      = tmp_reg;
                op_b      = NW'(dt_reg);
            end
            hpc_pkg::OP_PMUL:
            begin
                cmd.steps = hpc_pkg::STEPS_ERR;
                op_a      = NW'(gain_p_reg);
                op_b      = NW'(e_abs[hpc_pkg::STEPS_ERR-1:0]);
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        integ_next     = integ_reg;
        perr_next      = perr_reg;
        ptime_next     = ptime_reg;
        e_next         = e_reg;
        dt_next        = dt_reg;
        tmp_next       = tmp_reg;
        iterm_next     = iterm_reg;
        dterm_next     = dterm_reg;
        pterm_next     = pterm_reg;
        sum_next       = sum_reg;
        drive_next     = drive_reg;
        clamped_next   = clamped_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            op_next    = hpc_pkg::OP_INC;
            e_next     = wrap2[hpc_pkg::HEAD_W-1:0];
            dt_next    = dt_in;
            ptime_next = timestamp_us;
            if (restart)
            begin
                integ_next = '0;
            end
        end

        if ((state_reg == hpc_pkg::S_RUN) && unit_done)
        begin
            unique case (op_reg)
                hpc_pkg::OP_INC:
                begin
                    if (sat_sum > I_MAX)
                    begin
                        integ_next = I_MAX[IW-1:0];
                    end
                    else if (sat_sum < I_MIN)
                    begin
                        integ_next = I_MIN[IW-1:0];
                    end
                    else
                    begin
                        integ_next = sat_sum[IW-1:0];
                    end
                    op_next = hpc_pkg::OP_IMUL;
                end
                hpc_pkg::OP_IMUL:
                begin
                    tmp_next = unit_res;
                    op_next  = hpc_pkg::OP_IDIV;
                end
                hpc_pkg::OP_IDIV:
                begin
                    iterm_next = unit_res;
                    op_next    = hpc_pkg::OP_DMUL;
                end
                hpc_pkg::OP_DMUL:
                begin
                    tmp_next = unit_res;
                    op_next  = hpc_pkg::OP_DSCALE;
                end
                hpc_pkg::OP_DSCALE:
                begin
                    tmp_next = unit_res;
                    op_next  = hpc_pkg::OP_DDIV;
                end
                hpc_pkg::OP_DDIV:
                begin
                    // zero dt: derivative taken as zero
                    dterm_next = (dt_reg == '0) ? '0 : unit_res;
                    op_next    = hpc_pkg::OP_PMUL;
                end
                hpc_pkg::OP_PMUL:
                begin
                    pterm_next = unit_res[hpc_pkg::PTERM_W-1:0];
                end
                default:
                begin
                    op_next = hpc_pkg::OP_INC;
                end
            endcase
        end

        if (state_reg == hpc_pkg::S_SUM)
        begin
            sum_next = p_s + i_s + d_s;
        end

        if ((state_reg == hpc_pkg::S_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            clamped_next   = over;
            drive_next     = sum_reg[SW-1] ? $signed(mag8) : -$signed(mag8);
            perr_next      = e_reg;
            if (in_band)
            begin
                integ_next = '0;
            end
        end
    end

    // control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpc_pkg::S_IDLE;
            op_reg        <= hpc_pkg::OP_INC;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            perr_reg      <= '0;
            ptime_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            perr_reg      <= perr_next;
            ptime_reg     <= ptime_next;
        end
    end

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= hpc_pkg::RST_TARGET;
            gain_p_reg <= hpc_pkg::RST_GAIN_P;
            gain_i_reg <= hpc_pkg::RST_GAIN_I;
            gain_d_reg <= hpc_pkg::RST_GAIN_D;
            limit_reg  <= hpc_pkg::RST_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hpc_pkg::REG_TARGET: target_reg <= cfg_data[hpc_pkg::HEAD_W-1:0];
                hpc_pkg::REG_GAIN_P: gain_p_reg <= cfg_data;
                hpc_pkg::REG_GAIN_I: gain_i_reg <= cfg_data;
                hpc_pkg::REG_GAIN_D: gain_d_reg <= cfg_data;
                hpc_pkg::REG_LIMIT:  limit_reg  <= cfg_data[hpc_pkg::LIMIT_W-1:0];
                default:             limit_reg  <= limit_reg;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        e_reg       <= e_next;
        dt_reg      <= dt_next;
        tmp_reg     <= tmp_next;
        iterm_reg   <= iterm_next;
        dterm_reg   <= dterm_next;
        pterm_reg   <= pterm_next;
        sum_reg     <= sum_next;
        drive_reg   <= drive_next;
        clamped_reg <= clamped_next;
    end

    hpc_serial_unit #(
        .WIDTH (NW)
    ) u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .op_a   (op_a),
        .op_b   (op_b),
        .result (unit_res),
        .done   (unit_done)
    );

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

    `HPC_ASSERT_NEXT(a_accept_launch, in_valid && !in_stall, state_reg == hpc_pkg::S_LAUNCH)
    `HPC_ASSERT(a_dt_zero, (state_reg == hpc_pkg::S_SUM) && (dt_reg == '0) |-> (dterm_reg == '0))
    `HPC_ASSERT_NEXT(a_out_load, (state_reg == hpc_pkg::S_DONE) && out_free, out_valid_reg)

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int  N_PHASES   = 8;
    localparam int  PHASE_LEN  = 200;
    localparam int  CYCLE_CAP  = 2000000;
    localparam int  DRAIN_WAIT = 250;     // extra wait after the last expected result
    localparam int  HOLD_OFF   = 1500;    // long output hold-off, in cycles

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic [hpc_pkg::HEAD_W-1:0]         heading;
    logic [hpc_pkg::TIME_W-1:0]         timestamp_us;
    logic                               restart;
    logic                               out_valid;
    logic                               out_stall;
    logic signed [hpc_pkg::DRIVE_W-1:0] drive;
    logic                               clamped;
    logic                               cfg_we;
    logic [hpc_pkg::IDX_W-1:0]          cfg_index;
    logic [hpc_pkg::CFG_W-1:0]          cfg_data;

    heading_pid_controller_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .heading      (heading),
        .timestamp_us (timestamp_us),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive        (drive),
        .clamped      (clamped),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // one drive result, plus a flag telling whether it was typed in by hand
    typedef struct {
        bit                                 typed;
        logic signed [hpc_pkg::DRIVE_W-1:0] drv;
        bit                                 clp;
    } drive_res_t;

    // directed table row: either a register write or a heading sample
    typedef struct {
        bit                                 is_cfg;
        logic [hpc_pkg::IDX_W-1:0]          idx;
        logic [hpc_pkg::CFG_W-1:0]          data;
        logic [hpc_pkg::HEAD_W-1:0]         hd;
        logic [hpc_pkg::TIME_W-1:0]         ts;
        bit                                 rs;
        drive_res_t                         res;
    } row_t;

    // predictor copy of the registers
    longint tgt_q, gp_q, gi_q, gd_q, lim_q;
    // predictor copy of the loop state
    longint integ_q, prev_err_q;
    logic [hpc_pkg::TIME_W-1:0] prev_ts_q;

    drive_res_t expected_drive_q[$];   // predicted results awaiting transfer
    drive_res_t hand_drive_q[$];       // per sent item, hand-typed result if any
    row_t       rows[$];

    int  mismatches;
    int  cycles;
    int  rx_count;
    bit  tx_busy;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: one heading sample in, one drive result out.
    // ------------------------------------------------------------------
    function automatic drive_res_t predict_drive(input logic [hpc_pkg::HEAD_W-1:0] hd,
                                                 input logic [hpc_pkg::TIME_W-1:0] ts,
                                                 input bit rs);
        drive_res_t                 res;
        longint                     err, dt, inc, q, r, pt, it, dd, sum, v, hi, lo;
        logic [hpc_pkg::TIME_W-1:0] d32;
        res.typed = 1'b0;
        res.clp   = 1'b0;
        if (rs)
        begin
            integ_q   = 0;
            prev_ts_q = '0;
        end
        // wrap the error once by a full turn each way
        err = longint'(hd) - tgt_q;
        if (err <= -180) err += 360;
        if (err >= 180)  err -= 360;
        d32 = ts - prev_ts_q;              // modulo 2^32 time difference
        dt  = longint'({32'b0, d32});
        // doubled trapezoid, saturating at 48 bits signed
        inc = (err + prev_err_q) * dt;
        hi  = (longint'(1) <<< 47) - 1;
        lo  = -hi - 1;
        if (inc > 0 && integ_q > hi - inc)      integ_q = hi;
        else if (inc < 0 && integ_q < lo - inc) integ_q = lo;
        else                                    integ_q = integ_q + inc;
        pt = gp_q * err;
        // split the divide so gain * integral never overflows 64 bits
        q  = integ_q / 2000000;
        r  = integ_q % 2000000;
        it = gi_q * q + (gi_q * r) / 2000000;
        dd = (dt == 0) ? 0 : (gd_q * (err - prev_err_q) * 1000000) / dt;
        sum = pt + it + dd;
        v   = (-sum) / 4096;
        if (v > lim_q)
        begin
            v = lim_q;
            res.clp = 1'b1;
        end
        else if (v < -lim_q)
        begin
            v = -lim_q;
            res.clp = 1'b1;
        end
        prev_ts_q  = ts;
        prev_err_q = err;
        if (err >= -5 && err <= 5) integ_q = 0;   // deadband clears integral
        res.drv = v[hpc_pkg::DRIVE_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: all sampling happens at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        drive_res_t pred, hand, want;
        if (!rst_n)
        begin
            tgt_q      = longint'(hpc_pkg::RST_TARGET);
            gp_q       = longint'(hpc_pkg::RST_GAIN_P);
            gi_q       = longint'(hpc_pkg::RST_GAIN_I);
            gd_q       = longint'(hpc_pkg::RST_GAIN_D);
            lim_q      = longint'(hpc_pkg::RST_LIMIT);
            integ_q    = 0;
            prev_err_q = 0;
            prev_ts_q  = '0;
        end
        else
        begin
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("FAILURE");
                $finish;
            end
            else
            begin
                if (cfg_we)
                begin
                    case (cfg_index)
                        hpc_pkg::REG_TARGET:
                            tgt_q = longint'(cfg_data[hpc_pkg::HEAD_W-1:0]);
                        hpc_pkg::REG_GAIN_P: gp_q  = longint'(cfg_data);
                        hpc_pkg::REG_GAIN_I: gi_q  = longint'(cfg_data);
                        hpc_pkg::REG_GAIN_D: gd_q  = longint'(cfg_data);
                        hpc_pkg::REG_LIMIT:
                            lim_q = longint'(cfg_data[hpc_pkg::LIMIT_W-1:0]);
                        default: ;
                    endcase
                end
                // input transfer: run the predictor, prefer a hand-typed value
                if (in_valid && !in_stall)
                begin
                    pred = predict_drive(heading, timestamp_us, restart);
                    hand = hand_drive_q.pop_front();
                    if (hand.typed)
                        expected_drive_q.push_back(hand);
                    else
                        expected_drive_q.push_back(pred);
                end
                // output transfer: compare against the oldest expectation
                if (out_valid && !out_stall)
                begin
                    rx_count++;
                    if (expected_drive_q.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("unexpected result drive=%0d clamped=%0b",
                                     drive, clamped);
                    end
                    else
                    begin
                        want = expected_drive_q.pop_front();
                        if (drive !== want.drv || clamped !== want.clp)
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("result %0d: drive exp %0d got %0d, clamped exp %0b got %0b",
                                         rx_count, want.drv, drive, want.clp, clamped);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall per result, plus one long hold-off.
    // ------------------------------------------------------------------
    initial
    begin
        int  n;
        bit  quiet;
        bit  held;
        out_stall = 1'b1;
        quiet     = 1'b0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 29) == 0) quiet = ~quiet;
            n = quiet ? 0 : $urandom_range(0, 13);
            // long stall once the pipe is running, sender keeps offering
            if (!held && rx_count >= 30)
            begin
                held = 1'b1;
                n    = HOLD_OFF;
            end
            @(negedge clk);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [hpc_pkg::HEAD_W-1:0] hd,
                               input logic [hpc_pkg::TIME_W-1:0] ts,
                               input bit rs, input drive_res_t hand);
        int gap;
        gap = tx_busy ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        hand_drive_q.push_back(hand);
        in_valid     <= 1'b1;
        heading      <= hd;
        timestamp_us <= ts;
        restart      <= rs;
        do @(posedge clk); while (in_stall);
    endtask

    // registers change only with nothing in flight
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_drive_q.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [hpc_pkg::IDX_W-1:0] idx,
                             input logic [hpc_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic row_t row_item(input logic [hpc_pkg::HEAD_W-1:0] hd,
                                      input logic [hpc_pkg::TIME_W-1:0] ts,
                                      input bit rs, input bit typed,
                                      input int drv, input bit clp);
        row_t r;
        r = '{default: '0};
        r.hd = hd;
        r.ts = ts;
        r.rs = rs;
        r.res.typed = typed;
        r.res.drv   = drv[hpc_pkg::DRIVE_W-1:0];
        r.res.clp   = clp;
        return r;
    endfunction

    function automatic row_t row_cfg(input logic [hpc_pkg::IDX_W-1:0] idx,
                                     input logic [hpc_pkg::CFG_W-1:0] val);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = val;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        drive_res_t                 none;
        logic [hpc_pkg::TIME_W-1:0] ts;
        logic [hpc_pkg::HEAD_W-1:0] hd;
        int                         pick, tgt_now;
        bit                         rs, big_dt;
        // per phase: target, P, I, D gains, output limit
        int ph_tgt[N_PHASES];
        int ph_gp [N_PHASES];
        int ph_gi [N_PHASES];
        int ph_gd [N_PHASES];
        int ph_lim[N_PHASES];

        ph_tgt = '{90, 0, 359, 511, 200, 45, 300, 10};
        ph_gp  = '{6144, 65535, 0, 8000, 4096, 65535, 0, 0};
        ph_gi  = '{6144, 65535, 0, 12000, 300, 0, 65535, 0};
        ph_gd  = '{614, 65535, 0, 100, 2000, 0, 0, 65535};
        ph_lim = '{60, 127, 0, 1, 100, 127, 50, 127};

        none      = '{default: '0};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        heading   = '0;
        timestamp_us = '0;
        restart   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        mismatches = 0;
        cycles    = 0;
        rx_count  = 0;
        tx_busy   = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part: rows with restart at time zero have zero dt, which keeps I and D out, so P alone sets drive
        rows.push_back(row_item(0,   0, 1, 1, 0,   0));   // straight after reset
        rows.push_back(row_item(10,  0, 1, 1, -15, 0));
        rows.push_back(row_item(100, 0, 1, 1, -60, 1));
        rows.push_back(row_item(260, 0, 1, 1, 60,  1));   // wraps to -100
        rows.push_back(row_item(180, 0, 1, 1, 60,  1));   // wraps to -180
        rows.push_back(row_item(179, 0, 1, 1, -60, 1));
        rows.push_back(row_item(511, 0, 1, 1, -60, 1));   // heading above 359
        rows.push_back(row_item(3,   0, 1, 1, -4,  0));   // truncation toward zero
        rows.push_back(row_item(20,  1000, 0, 0, 0, 0));
        rows.push_back(row_item(20,  1000, 0, 0, 0, 0));  // zero dt
        rows.push_back(row_item(300, 32'hFFFF_FF00, 0, 0, 0, 0));
        rows.push_back(row_item(50,  32'h0000_0100, 0, 0, 0, 0));  // timer wrap
        rows.push_back(row_item(0,   500000, 1, 0, 0, 0));  // restart, dt = timestamp
        rows.push_back(row_cfg(hpc_pkg::REG_LIMIT, 0));
        rows.push_back(row_item(90,  600000, 0, 0, 0, 0));
        rows.push_back(row_item(0,   600000, 1, 0, 0, 0));
        rows.push_back(row_cfg(hpc_pkg::REG_TARGET, 359));
        rows.push_back(row_cfg(hpc_pkg::REG_GAIN_P, 16'hFFFF));
        rows.push_back(row_cfg(hpc_pkg::REG_GAIN_I, 16'hFFFF));
        rows.push_back(row_cfg(hpc_pkg::REG_GAIN_D, 16'hFFFF));
        rows.push_back(row_cfg(hpc_pkg::REG_LIMIT, 127));
        rows.push_back(row_item(0,   0, 1, 1, -15, 0));
        rows.push_back(row_item(179, 1, 0, 0, 0, 0));
        rows.push_back(row_item(511, 32'hFFFF_FFFF, 0, 0, 0, 0));
        rows.push_back(row_cfg(hpc_pkg::REG_TARGET, 0));
        rows.push_back(row_cfg(hpc_pkg::REG_GAIN_P, 0));
        rows.push_back(row_cfg(hpc_pkg::REG_GAIN_I, 0));
        rows.push_back(row_cfg(hpc_pkg::REG_GAIN_D, 0));
        rows.push_back(row_item(255, 7, 0, 1, 0, 0));     // all gains zero

        foreach (rows[k])
        begin
            if (rows[k].is_cfg)
            begin
                wait_idle();
                write_reg(rows[k].idx, rows[k].data);
            end
            else
                send_sample(rows[k].hd, rows[k].ts, rows[k].rs, rows[k].res);
        end

        // random part, one register setting per phase
        ts = 32'd7;
        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            write_reg(hpc_pkg::REG_TARGET, hpc_pkg::CFG_W'(ph_tgt[p]));
            write_reg(hpc_pkg::REG_GAIN_P, hpc_pkg::CFG_W'(ph_gp[p]));
            write_reg(hpc_pkg::REG_GAIN_I, hpc_pkg::CFG_W'(ph_gi[p]));
            write_reg(hpc_pkg::REG_GAIN_D, hpc_pkg::CFG_W'(ph_gd[p]));
            write_reg(hpc_pkg::REG_LIMIT,  hpc_pkg::CFG_W'(ph_lim[p]));
            tgt_now = ph_tgt[p];
            // two phases run long time steps to drive the integral into saturation
            big_dt = (p == 1 || p == 6);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if ($urandom_range(0, 39) == 0) tx_busy = ~tx_busy;
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    ;                                   // same timestamp, dt = 0
                else if (pick < 16 || (big_dt && pick < 70))
                    ts = ts + $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
                else if (pick < 20)
                    ts = $urandom;
                else
                    ts = ts + $urandom_range(1, 50000);
                pick = $urandom_range(0, 99);
                if (pick < 30)                          // near deadband
                    hd = hpc_pkg::HEAD_W'((tgt_now + 353 + $urandom_range(0, 14)) % 360);
                else if (pick < 90)
                    hd = hpc_pkg::HEAD_W'($urandom_range(0, 359));
                else
                    hd = hpc_pkg::HEAD_W'($urandom_range(360, 511));
                rs = ($urandom_range(0, 32) == 0);
                send_sample(hd, ts, rs, none);
            end
        end

        // drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_drive_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_drive_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* heading_pid_controller_top.f */
+incdir+rtl
rtl/hpc_pkg.sv
rtl/hpc_serial_unit.sv
rtl/heading_pid_controller_top.sv
tb/sv/tb_top.sv
